[hw/rtl/mmp_pkg.sv]
// Shared types and constants for the 2x2 modular matrix power block.
package mmp_pkg;

	localparam int unsigned ENTRY_W = 30;
	localparam int unsigned POWER_W = 31;

	// Prime modulus and its doubled value for the final correction
	localparam logic [ENTRY_W-1:0] MODULUS    = 30'd1000000007;
	localparam logic [31:0]        MODULUS_X2 = 32'd2000000014;

	// Barrett constant floor(2^60 / MODULUS), fits in 31 bits
	localparam logic [30:0] BARRETT_MU = 31'((64'd1 << 60) / 64'd1000000007);

	// Latency of the shared modular multiplier in cycles
	localparam int unsigned MODMUL_LAT = 5;

	typedef struct packed {
		logic [ENTRY_W-1:0] m_top_left;
		logic [ENTRY_W-1:0] m_top_right;
		logic [ENTRY_W-1:0] m_bottom_left;
		logic [ENTRY_W-1:0] m_bottom_right;
		logic [POWER_W-1:0] power;
	} mmp_req_t;

	typedef struct packed {
		logic [ENTRY_W-1:0] r_top_left;
		logic [ENTRY_W-1:0] r_top_right;
		logic [ENTRY_W-1:0] r_bottom_left;
		logic [ENTRY_W-1:0] r_bottom_right;
	} mmp_rsp_t;

endpackage

[hw/rtl/mmp_modmul.sv]
// Pipelined modular multiplier: one product a*b mod MODULUS per cycle, Barrett reduction.
module mmp_modmul
	import mmp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [ENTRY_W-1:0] a,
	input  logic [ENTRY_W-1:0] b,
	output logic               out_valid,
	output logic [ENTRY_W-1:0] y
);

	logic [MODMUL_LAT-1:0] vld_q;
	logic [59:0]           prod_s1;
	logic [61:0]           quot_s2;
	logic [31:0]           low_s2;
	logic [31:0]           qm_s3;
	logic [31:0]           low_s3;
	logic [31:0]           rem_s4;
	logic [ENTRY_W-1:0]    res_s5;

	logic [30:0] quot_est;
	logic [60:0] qm_full;
	logic [31:0] rem_fix;

	// Advance the valid flags alongside the data stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[MODMUL_LAT-2:0], in_valid};
		end
	end

	// Multiply the operands
	always_ff @(posedge clk) begin
		prod_s1 <= 60'(a) * 60'(b);
	end

	// Estimate the quotient from the upper product bits
	always_ff @(posedge clk) begin
		quot_s2 <= 62'(prod_s1[59:29]) * 62'(BARRETT_MU);
		low_s2  <= prod_s1[31:0];
	end

	// Form quotient times modulus; only the low word matters since remainder < 3*MODULUS
	assign quot_est = quot_s2[61:31];
	assign qm_full  = 61'(quot_est) * 61'(MODULUS);

	always_ff @(posedge clk) begin
		qm_s3  <= qm_full[31:0];
		low_s3 <= low_s2;
	end

	// Subtract to get the partial remainder
	always_ff @(posedge clk) begin
		rem_s4 <= low_s3 - qm_s3;
	end

	// Drop up to two multiples of the modulus
	always_comb begin
		if (rem_s4 >= MODULUS_X2) begin
			rem_fix = rem_s4 - MODULUS_X2;
		end else if (rem_s4 >= 32'(MODULUS)) begin
			rem_fix = rem_s4 - 32'(MODULUS);
		end else begin
			rem_fix = rem_s4;
		end
	end

	always_ff @(posedge clk) begin
		res_s5 <= rem_fix[ENTRY_W-1:0];
	end

	assign out_valid = vld_q[MODMUL_LAT-1];
	assign y         = res_s5;

endmodule

[hw/rtl/modular_matrix_power_2x2.sv]
// Top level: 2x2 matrix power modulo 1000000007 by left-to-right square-and-multiply.
//
// Raise start while busy is low to hand in a request; busy stays high while the
// request is worked on. Each exponent bit costs one matrix square, plus one
// multiply by the input matrix when the bit is set. A matrix product issues its
// eight modular products, one per cycle, into a single five-stage modular
// multiplier and collects all eight results before the next product starts.
// The result is shown for exactly one cycle with done high, in the first cycle
// with busy low again; it cannot be stalled and must be captured then. Only the low
// EXP_WIDTH bits of power are used, and entries at or above the modulus are
// taken as their residues.
module modular_matrix_power_2x2
	import mmp_pkg::*;
#(
	parameter int unsigned EXP_WIDTH = 31
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  mmp_req_t request,
	output logic     busy,
	output logic     done,
	output mmp_rsp_t result
);

	localparam int unsigned BITS_W = $clog2(EXP_WIDTH + 1);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_ISSUE  = 2'd1;
	localparam logic [1:0] ST_DRAIN  = 2'd2;
	localparam logic [1:0] ST_UPDATE = 2'd3;

	logic [1:0]           state_q;
	logic                 phase_mul_q;
	logic [EXP_WIDTH-1:0] exp_q;
	logic [BITS_W-1:0]    bits_left_q;
	logic [2:0]           issue_cnt_q;
	logic [2:0]           res_cnt_q;
	logic                 done_q;
	mmp_rsp_t             result_q;

	logic [ENTRY_W-1:0] acc_q  [4];
	logic [ENTRY_W-1:0] base_q [4];
	logic [ENTRY_W-1:0] next_q [4];
	logic [ENTRY_W-1:0] first_q;

	logic               accept;
	logic [1:0]         x_idx;
	logic [1:0]         y_idx;
	logic [ENTRY_W-1:0] mul_a;
	logic [ENTRY_W-1:0] mul_b;
	logic               mul_in_valid;
	logic               mul_out_valid;
	logic [ENTRY_W-1:0] mul_y;
	logic [ENTRY_W:0]   pair_sum;
	logic [ENTRY_W-1:0] pair_mod;
	logic               last_step;

	assign accept = start && !busy;

	// Reduce an input entry below the modulus; one subtract suffices for 30 bits
	function automatic logic [ENTRY_W-1:0] reduce_entry(input logic [ENTRY_W-1:0] v);
		reduce_entry = (v >= MODULUS) ? v - MODULUS : v;
	endfunction

	// Select operands: term k[0] of entry {k[2], k[1]}
	assign x_idx        = {issue_cnt_q[2], issue_cnt_q[0]};
	assign y_idx        = {issue_cnt_q[0], issue_cnt_q[1]};
	assign mul_a        = acc_q[x_idx];
	assign mul_b        = phase_mul_q ? base_q[y_idx] : acc_q[y_idx];
	assign mul_in_valid = (state_q == ST_ISSUE);

	mmp_modmul u_modmul (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mul_in_valid),
		.a         (mul_a),
		.b         (mul_b),
		.out_valid (mul_out_valid),
		.y         (mul_y)
	);

	// Add the two products of one entry modulo the prime
	assign pair_sum = {1'b0, first_q} + {1'b0, mul_y};
	assign pair_mod = (pair_sum >= {1'b0, MODULUS}) ?
		ENTRY_W'(pair_sum - {1'b0, MODULUS}) : pair_sum[ENTRY_W-1:0];

	// The current product is the last one of the request
	assign last_step = (phase_mul_q || !exp_q[EXP_WIDTH-1]) && (bits_left_q == BITS_W'(1));

	// Sequence the square and multiply steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_mul_q <= 1'b0;
			issue_cnt_q <= '0;
			res_cnt_q   <= '0;
			bits_left_q <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= (state_q == ST_UPDATE) && last_step;
			if (mul_out_valid) begin
				res_cnt_q <= res_cnt_q + 3'd1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q     <= ST_ISSUE;
						phase_mul_q <= 1'b0;
						issue_cnt_q <= '0;
						bits_left_q <= BITS_W'(EXP_WIDTH);
					end
				end
				ST_ISSUE: begin
					issue_cnt_q <= issue_cnt_q + 3'd1;
					if (issue_cnt_q == 3'd7) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (mul_out_valid && res_cnt_q == 3'd7) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (last_step) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_ISSUE;
						if (!phase_mul_q && exp_q[EXP_WIDTH-1]) begin
							phase_mul_q <= 1'b1;
						end else begin
							phase_mul_q <= 1'b0;
							bits_left_q <= bits_left_q - BITS_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Load the request, hold the running matrix and advance the exponent
	always_ff @(posedge clk) begin
		if (accept) begin
			base_q[0] <= reduce_entry(request.m_top_left);
			base_q[1] <= reduce_entry(request.m_top_right);
			base_q[2] <= reduce_entry(request.m_bottom_left);
			base_q[3] <= reduce_entry(request.m_bottom_right);
			acc_q[0]  <= ENTRY_W'(1);
			acc_q[1]  <= '0;
			acc_q[2]  <= '0;
			acc_q[3]  <= ENTRY_W'(1);
			exp_q     <= EXP_WIDTH'(request.power);
		end else if (state_q == ST_UPDATE) begin
			acc_q <= next_q;
			if (phase_mul_q || !exp_q[EXP_WIDTH-1]) begin
				exp_q <= exp_q << 1;
			end
		end
	end

	// Collect product pairs into the next matrix
	always_ff @(posedge clk) begin
		if (mul_out_valid) begin
			if (!res_cnt_q[0]) begin
				first_q <= mul_y;
			end else begin
				next_q[res_cnt_q[2:1]] <= pair_mod;
			end
		end
	end

	// Hold the finished matrix for the result strobe
	always_ff @(posedge clk) begin
		if (state_q == ST_UPDATE && last_step) begin
			result_q.r_top_left     <= next_q[0];
			result_q.r_top_right    <= next_q[1];
			result_q.r_bottom_left  <= next_q[2];
			result_q.r_bottom_right <= next_q[3];
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule
